@@ src/lwf_pkg.sv @@
package lwf_pkg;

  localparam int unsigned RANGE_W  = 16;
  localparam int unsigned BEAM_W   = 10;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned ANG_W    = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_SECTORS = 3;

  localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

  localparam logic [CFG_DATA_W-1:0] NEAR_THRESHOLD_RST = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] SPEED_RST          = 16'd400;

  // opcodes of the request channel
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED          = 1'b1;

  // sector slots in the minima arrays
  localparam logic [1:0] SEC_RIGHT = 2'd0;
  localparam logic [1:0] SEC_FRONT = 2'd1;
  localparam logic [1:0] SEC_LEFT  = 2'd2;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_t;

  typedef logic [RANGE_W-1:0] range_t;

endpackage

@@ src/lwf_req_if.sv @@
interface lwf_req_if
  import lwf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BEAM_W-1:0] beam_index;
  range_t            range_mm;

  modport source (output valid, output opcode, output beam_index, output range_mm,
                  input ready);
  modport sink   (input valid, input opcode, input beam_index, input range_mm,
                  output ready);
endinterface

@@ src/lwf_res_if.sv @@
interface lwf_res_if
  import lwf_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [SPEED_W-1:0]       linear_speed;
  logic signed [ANG_W-1:0]  angular_speed;
  logic [1:0]               followed_side;

  modport source (output valid, output linear_speed, output angular_speed,
                  output followed_side, input ready);
  modport sink   (input valid, input linear_speed, input angular_speed,
                  input followed_side, output ready);
endinterface

@@ src/lidar_wall_follow_controller_unit.sv @@
// Flow: a request is registered in the input register on acceptance; a tick's command is
//   then loaded into the output register, which drives out_res.
// Throughput: one request per cycle unless a tick waits. A tick waits in the input register
//   only while the previous command is still held in the output register and not being
//   taken; samples never wait.
// Reset (rst_n, synchronous, active low): both stages empty, all sector minima 65535,
//   no wall latched, near threshold 1000 mm, speed magnitude 400.
module lidar_wall_follow_controller_unit
  import lwf_pkg::*;
#(
  parameter int unsigned SECTOR_BEAMS = 240
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lwf_req_if.sink               in_req,
  lwf_res_if.source             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // wide enough to hold 3 * SECTOR_BEAMS at the top of its range
  localparam int unsigned CMP_W     = 13;
  localparam int unsigned LAST_BEAM = 3 * SECTOR_BEAMS - 1;

  // configuration
  logic [CFG_DATA_W-1:0] thr_r;
  logic [CFG_DATA_W-1:0] spd_r;

  // input stage
  logic              s1_valid_r;
  logic              s1_op_r;
  logic [BEAM_W-1:0] s1_beam_r;
  range_t            s1_range_r;

  // block state
  range_t work_r [NUM_SECTORS];
  range_t comm_r [NUM_SECTORS];
  range_t work_nxt [NUM_SECTORS];
  range_t comm_nxt [NUM_SECTORS];
  side_t  wall_side_r;
  side_t  wall_side_nxt;

  // result stage
  logic                    out_valid_r;
  logic [SPEED_W-1:0]      out_lin_r;
  logic [SPEED_W-1:0]      out_lin_nxt;
  logic signed [ANG_W-1:0] out_ang_r;
  logic signed [ANG_W-1:0] out_ang_nxt;
  side_t                   out_side_r;

  logic             s1_fire;
  logic             tick_fire;
  logic             commit_en;
  logic             in_scan;
  logic [1:0]       sec;
  logic [CMP_W-1:0] beam_ext;
  logic             rn, fn, ln, rf, ff, lf;
  logic signed [ANG_W-1:0] pos_spd;
  logic signed [ANG_W-1:0] neg_spd;

  assign s1_fire   = s1_valid_r && ((s1_op_r == OP_SAMPLE) || !out_valid_r || out_res.ready);
  assign tick_fire = s1_fire && (s1_op_r == OP_TICK);
  assign in_req.ready = !s1_valid_r || s1_fire;

  // sector decode by compare, no divide
  always_comb begin
    beam_ext = CMP_W'(s1_beam_r);
    in_scan  = 1'b1;
    sec      = SEC_RIGHT;
    if (beam_ext < CMP_W'(SECTOR_BEAMS)) begin
      sec = SEC_RIGHT;
    end else if (beam_ext < CMP_W'(2 * SECTOR_BEAMS)) begin
      sec = SEC_FRONT;
    end else if (beam_ext < CMP_W'(3 * SECTOR_BEAMS)) begin
      sec = SEC_LEFT;
    end else begin
      in_scan = 1'b0;
    end
  end

  assign commit_en = s1_fire && (s1_op_r == OP_SAMPLE) && in_scan &&
                     (beam_ext == CMP_W'(LAST_BEAM));

  assign rn = comm_r[SEC_RIGHT] < thr_r;
  assign fn = comm_r[SEC_FRONT] < thr_r;
  assign ln = comm_r[SEC_LEFT]  < thr_r;
  assign rf = comm_r[SEC_RIGHT] > thr_r;
  assign ff = comm_r[SEC_FRONT] > thr_r;
  assign lf = comm_r[SEC_LEFT]  > thr_r;

  assign pos_spd = signed'({1'b0, spd_r});
  assign neg_spd = -pos_spd;

  always_comb begin
    work_nxt      = work_r;
    comm_nxt      = comm_r;
    wall_side_nxt = wall_side_r;
    out_lin_nxt   = spd_r;
    out_ang_nxt   = '0;

    if (s1_fire && (s1_op_r == OP_SAMPLE) && in_scan) begin
      for (int k = 0; k < NUM_SECTORS; k++) begin
        if ((sec == 2'(k)) && (s1_range_r < work_r[k])) begin
          work_nxt[k] = s1_range_r;
        end
      end
      if (commit_en) begin
        comm_nxt = work_nxt;
        for (int k = 0; k < NUM_SECTORS; k++) begin
          work_nxt[k] = RANGE_MAX;
        end
      end
    end

    if (tick_fire) begin
      if ((wall_side_r == SIDE_NONE) && (rn || fn || ln)) begin
        wall_side_nxt = (comm_r[SEC_RIGHT] < comm_r[SEC_LEFT]) ? SIDE_RIGHT : SIDE_LEFT;
      end
    end

    unique case (wall_side_nxt)
      SIDE_RIGHT: begin
        if (rf && ff && lf) begin
          out_lin_nxt = '0;
          out_ang_nxt = neg_spd;
        end else if (rn && ff) begin
          out_lin_nxt = spd_r;
          out_ang_nxt = '0;
        end else begin
          out_lin_nxt = '0;
          out_ang_nxt = pos_spd;
        end
      end
      SIDE_LEFT: begin
        if (rf && ff && lf) begin
          out_lin_nxt = '0;
          out_ang_nxt = pos_spd;
        end else if (ln && ff) begin
          out_lin_nxt = spd_r;
          out_ang_nxt = '0;
        end else begin
          out_lin_nxt = '0;
          out_ang_nxt = neg_spd;
        end
      end
      default: begin
        out_lin_nxt = spd_r;
        out_ang_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= NEAR_THRESHOLD_RST;
      spd_r <= SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEAR_THRESHOLD: thr_r <= cfg_wdata;
        CFG_SPEED:          spd_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wall_side_r <= SIDE_NONE;
      for (int k = 0; k < NUM_SECTORS; k++) begin
        work_r[k] <= RANGE_MAX;
        comm_r[k] <= RANGE_MAX;
      end
    end else begin
      if (in_req.ready) begin
        s1_valid_r <= in_req.valid;
      end
      if (tick_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      wall_side_r <= wall_side_nxt;
      work_r      <= work_nxt;
      comm_r      <= comm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_op_r    <= in_req.opcode;
      s1_beam_r  <= in_req.beam_index;
      s1_range_r <= in_req.range_mm;
    end
    if (tick_fire) begin
      out_lin_r  <= out_lin_nxt;
      out_ang_r  <= out_ang_nxt;
      out_side_r <= wall_side_nxt;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.linear_speed  = out_lin_r;
  assign out_res.angular_speed = out_ang_r;
  assign out_res.followed_side = out_side_r;

  // once a wall is latched it stays
  a_side_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (wall_side_r != SIDE_NONE) |=> (wall_side_r == $past(wall_side_r)))
    else $error("latched wall side changed");

  // a held command always reports the current latched side
  a_side_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_side_r == wall_side_r))
    else $error("reported side differs from latched side");

  // a tick taken from the input stage always loads a command
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire |=> out_valid_r)
    else $error("tick did not produce a command");

  // committed minima move only on the last beam of a scan
  a_commit_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (comm_r[SEC_FRONT] != $past(comm_r[SEC_FRONT])) |-> ($past(commit_en) || $past(!rst_n)))
    else $error("committed minimum changed outside scan end");

endmodule

@@ tb/sv/lidar_wall_follow_controller_unit_test.sv @@
`timescale 1ns / 100ps

module lidar_wall_follow_controller_unit_test;
  import lwf_pkg::*;

  localparam int unsigned SECTOR_BEAMS = 240;
  localparam int unsigned SCAN_BEAMS   = 3 * SECTOR_BEAMS;
  localparam int unsigned SETTLE_CYC   = 4;

  typedef struct packed {
    logic [SPEED_W-1:0]      lin;
    logic signed [ANG_W-1:0] ang;
    logic [1:0]              side;
  } drive_cmd_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lwf_req_if req_ch ();
  lwf_res_if res_ch ();

  lidar_wall_follow_controller_unit #(
    .SECTOR_BEAMS(SECTOR_BEAMS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_res  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow state of the controller
  range_t          work_min [NUM_SECTORS];
  range_t          commit_min [NUM_SECTORS];
  side_t           wall;
  logic [15:0]     thr;
  logic [15:0]     spd;
  drive_cmd_t      drive_cmd_q [$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned items_sent;
  int unsigned cmd_errors;

  function automatic void predict_drive(logic op, logic [BEAM_W-1:0] beam, range_t rng);
    int unsigned sec;
    range_t      r, f, l;
    logic        rn, fn, ln, rf, ff, lf;
    drive_cmd_t  cmd;
    if (op == OP_SAMPLE) begin
      sec = beam / SECTOR_BEAMS;
      if (sec < NUM_SECTORS) begin
        if (rng < work_min[sec]) work_min[sec] = rng;
        if (beam == SCAN_BEAMS - 1) begin
          commit_min = work_min;
          work_min = '{default: RANGE_MAX};
        end
      end
      return;
    end
    r  = commit_min[SEC_RIGHT];
    f  = commit_min[SEC_FRONT];
    l  = commit_min[SEC_LEFT];
    rn = r < thr;
    fn = f < thr;
    ln = l < thr;
    rf = r > thr;
    ff = f > thr;
    lf = l > thr;
    if (wall == SIDE_NONE && (rn || fn || ln)) wall = (r < l) ? SIDE_RIGHT : SIDE_LEFT;
    cmd.lin = spd;
    cmd.ang = '0;
    case (wall)
      SIDE_RIGHT: begin
        if (rf && ff && lf) begin
          cmd.lin = '0;
          cmd.ang = '0 - {1'b0, spd};
        end else if (rn && ff) begin
          cmd.lin = spd;
        end else begin
          cmd.lin = '0;
          cmd.ang = {1'b0, spd};
        end
      end
      SIDE_LEFT: begin
        if (rf && ff && lf) begin
          cmd.lin = '0;
          cmd.ang = {1'b0, spd};
        end else if (ln && ff) begin
          cmd.lin = spd;
        end else begin
          cmd.lin = '0;
          cmd.ang = '0 - {1'b0, spd};
        end
      end
      default: begin
      end
    endcase
    cmd.side = wall;
    drive_cmd_q.push_back(cmd);
  endfunction

  // result side: random backpressure, compare against oldest expected command
  always @(negedge clk) begin
    res_ch.ready <= (snk_idle_pct == 0) || ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    drive_cmd_t exp_cmd;
    if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (drive_cmd_q.size() == 0) begin
        cmd_errors++;
        if (cmd_errors <= 10)
          $display("unexpected command: lin %0d ang %0d side %0d", res_ch.linear_speed,
                   res_ch.angular_speed, res_ch.followed_side);
      end else begin
        exp_cmd = drive_cmd_q.pop_front();
        if (res_ch.linear_speed !== exp_cmd.lin || res_ch.angular_speed !== exp_cmd.ang ||
            res_ch.followed_side !== exp_cmd.side) begin
          cmd_errors++;
          if (cmd_errors <= 10)
            $display("command mismatch: expected lin %0d ang %0d side %0d, got lin %0d ang %0d side %0d",
                     exp_cmd.lin, exp_cmd.ang, exp_cmd.side, res_ch.linear_speed,
                     res_ch.angular_speed, res_ch.followed_side);
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(logic op, logic [BEAM_W-1:0] beam, range_t rng);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid      = 1'b1;
    req_ch.opcode     = op;
    req_ch.beam_index = beam;
    req_ch.range_mm   = rng;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_drive(op, beam, rng);
    if (op == OP_TICK || beam < SCAN_BEAMS) items_sent++;
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic send_sample(int unsigned beam, range_t rng);
    send_request(OP_SAMPLE, beam[BEAM_W-1:0], rng);
  endtask

  task automatic send_tick();
    send_request(OP_TICK, BEAM_W'($urandom), range_t'($urandom));
  endtask

  task automatic wait_drained();
    while (drive_cmd_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    if (idx == CFG_NEAR_THRESHOLD) thr = val;
    else spd = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic range_t pick_range();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return RANGE_MAX;
      2: return thr - 1'b1;
      3: return thr;
      4: return thr + 1'b1;
      5: return range_t'($urandom_range(0, thr));
      6: return range_t'($urandom_range(thr, 65535));
      default: return range_t'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_tick();
    // beams past the scan must not touch any sector
    send_sample(1023, 16'd0);
    send_sample(SCAN_BEAMS, 16'd0);
    send_sample(SCAN_BEAMS - 1, RANGE_MAX);
    send_tick();
  endtask

  task automatic test_cfg_extremes();
    wait_drained();
    write_cfg(CFG_NEAR_THRESHOLD, 16'd0);
    write_cfg(CFG_SPEED, 16'hFFFF);
    send_sample(0, 16'd0);
    send_sample(SECTOR_BEAMS, 16'd0);
    send_sample(SCAN_BEAMS - 1, 16'd0);
    send_tick();
    // scan end only: right and front got no beams
    send_sample(SCAN_BEAMS - 1, RANGE_MAX);
    wait_drained();
    write_cfg(CFG_NEAR_THRESHOLD, 16'hFFFF);
    send_tick();
    wait_drained();
    write_cfg(CFG_SPEED, 16'd0);
    send_tick();
  endtask

  task automatic scan3(range_t r, range_t f, range_t l);
    send_sample($urandom_range(0, SECTOR_BEAMS - 1), r);
    send_sample($urandom_range(SECTOR_BEAMS, 2 * SECTOR_BEAMS - 1), f);
    send_sample(SCAN_BEAMS - 1, l);
    send_tick();
  endtask

  task automatic test_wall_latch_rules();
    wait_drained();
    write_cfg(CFG_NEAR_THRESHOLD, 16'd1000);
    write_cfg(CFG_SPEED, 16'd400);
    // the latched side is permanent, so the run picks one of right, left or tie
    case ($urandom_range(0, 2))
      0: scan3(16'd200, 16'd5000, 16'd600);
      1: scan3(16'd600, 16'd5000, 16'd200);
      default: scan3(16'd300, 16'd5000, 16'd300);
    endcase
    scan3(16'd2000, 16'd2000, 16'd2000);
    scan3(16'd100, 16'd5000, 16'd100);
    scan3(16'd100, 16'd100, 16'd100);
    // equal to threshold is neither near nor far
    scan3(16'd1000, 16'd5000, 16'd5000);
  endtask

  task automatic run_random_phase(int unsigned n_items);
    int unsigned target;
    int unsigned sel;
    int unsigned k;
    target = items_sent + n_items;
    while (items_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        wait_drained();
      end else if (sel < 63) begin
        k = $urandom_range(0, 8);
        repeat (k) send_sample($urandom_range(0, SCAN_BEAMS - 2), pick_range());
        send_sample(SCAN_BEAMS - 1, pick_range());
        repeat ($urandom_range(1, 3)) send_tick();
      end else if (sel < 78) begin
        repeat ($urandom_range(1, 2)) send_tick();
      end else if (sel < 92) begin
        send_sample($urandom_range(0, SCAN_BEAMS - 1), pick_range());
      end else begin
        send_sample($urandom_range(SCAN_BEAMS, 1023), range_t'($urandom));
      end
    end
  endtask

  task automatic randomize_cfg();
    wait_drained();
    if ($urandom_range(0, 3) == 0) write_cfg(CFG_NEAR_THRESHOLD, 16'($urandom));
    else write_cfg(CFG_NEAR_THRESHOLD, 16'($urandom_range(200, 4000)));
    write_cfg(CFG_SPEED, 16'($urandom_range(1, 65535)));
  endtask

  task automatic test_random_traffic();
    randomize_cfg();
    run_random_phase(430);
    wait_drained();
    src_idle_pct = 69;
    snk_idle_pct = 18;
    randomize_cfg();
    run_random_phase(430);
    wait_drained();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    randomize_cfg();
    run_random_phase(430);
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.opcode     = OP_SAMPLE;
    req_ch.beam_index = '0;
    req_ch.range_mm   = '0;
    res_ch.ready      = 1'b0;
    src_idle_pct      = 18;
    snk_idle_pct      = 69;
    items_sent        = 0;
    cmd_errors        = 0;
    work_min          = '{default: RANGE_MAX};
    commit_min        = '{default: RANGE_MAX};
    wall              = SIDE_NONE;
    thr               = NEAR_THRESHOLD_RST;
    spd               = SPEED_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_cfg_extremes();
    test_wall_latch_rules();
    test_random_traffic();

    while (drive_cmd_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (cmd_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
